// ===== rtl/flspm_pkg.sv =====
// Package with constants and reset values for the flash log sector pointer manager.
package flspm_pkg;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SLOT0_BASE  = 3'd0;
  localparam logic [2:0] CFG_SLOT1_BASE  = 3'd1;
  localparam logic [2:0] CFG_SLOT2_BASE  = 3'd2;
  localparam logic [2:0] CFG_SLOT3_BASE  = 3'd3;
  localparam logic [2:0] CFG_FIRST_SPAN  = 3'd4;
  localparam logic [2:0] CFG_OTHER_SPAN  = 3'd5;
  localparam logic [2:0] CFG_CKPT_BYTES  = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [31:0] SLOT0_BASE_RST = 32'h0801_0000;
  localparam logic [31:0] SLOT1_BASE_RST = 32'h0802_0000;
  localparam logic [31:0] SLOT2_BASE_RST = 32'h0804_0000;
  localparam logic [31:0] SLOT3_BASE_RST = 32'h0806_0000;
  localparam logic [21:0] FIRST_SPAN_RST = 22'd65535;
  localparam logic [21:0] OTHER_SPAN_RST = 22'd131071;
  localparam logic [12:0] CKPT_BYTES_RST = 13'd2048;

  // Largest read chunk in bytes, and the number of slots in use.
  localparam int unsigned READ_CHUNK = 1024;
  localparam int unsigned SLOT_COUNT = 4;
  localparam logic [1:0] LAST_SLOT =
      (SLOT_COUNT > 4) ? 2'd3 : 2'(SLOT_COUNT - 1);

  localparam logic [31:0] READ_CHUNK_W = 32'(READ_CHUNK);
  localparam logic [12:0] COUNT_MAX    = 13'd8191;

endpackage

// ===== rtl/flash_log_sector_pointer_manager_unit.sv =====
// Top level of the flash log sector pointer manager: request decode and pointer state.
// Requests pass the input stage register, then the output register; a stall can hold them.
// One item per cycle unless stalled; all pointer state updates in the single execute stage.
// The output register decouples the sides: a stalled result still lets the input stage fill.
// Reset (async, active low): configuration returns to its defaults, the log is empty,
// and the checkpoint byte count is zero. Configuration writes are always taken.
module flash_log_sector_pointer_manager_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  record_length_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic        erase_now_o,
  output logic [1:0]  erase_slot_o,
  output logic [31:0] start_address_o,
  output logic [10:0] byte_length_o,
  output logic        checkpoint_o,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import flspm_pkg::*;

  // Configuration registers
  logic [31:0] slot_base_q [4];
  logic [21:0] first_span_q;
  logic [21:0] other_span_q;
  logic [12:0] ckpt_bytes_q;

  // Log state
  logic [31:0] wp_q, wp_d;
  logic [31:0] rp_q, rp_d;
  logic [1:0]  ws_q, ws_d;
  logic [1:0]  rs_q, rs_d;
  logic        erased_q, erased_d;
  logic [31:0] wend_q [4];
  logic [31:0] wend_d [4];
  logic [12:0] cnt_q, cnt_d;

  // Input stage
  logic        s1_valid_q;
  logic [1:0]  req_q;
  logic [7:0]  len_q;

  // Output stage
  logic        out_valid_q;
  logic        status_q, erase_now_q, ckpt_q;
  logic [1:0]  erase_slot_q;
  logic [31:0] start_q;
  logic [10:0] blen_q;

  logic        status_d, erase_now_d, ckpt_d;
  logic [1:0]  erase_slot_d;
  logic [31:0] start_d;
  logic [10:0] blen_d;

  logic out_free, fire, in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Append datapath signals
  logic [31:0] base_ws, base_ws_inc, wp_place, wp_adv;
  logic [21:0] span_ws;
  logic [32:0] limit_w, sum_w;
  logic        nofit, full;
  logic [1:0]  ws_inc, ws_new;
  logic        erased_place;
  logic [13:0] cnt_sum;
  logic [12:0] cnt_sat;
  logic        ckpt_hit;

  // Read datapath signals
  logic [31:0] end_cur, end_next, base_rs_inc, diff_cur, diff_next, len_next;
  logic        rd_far, rd_rest;
  logic [1:0]  rs_inc;

  always_comb begin
    ws_inc       = ws_q + 2'd1;
    base_ws      = slot_base_q[ws_q];
    base_ws_inc  = slot_base_q[ws_inc];
    span_ws      = (ws_q == 2'd0) ? first_span_q : other_span_q;
    limit_w      = {1'b0, base_ws} + 33'(span_ws);
    sum_w        = {1'b0, wp_q} + 33'(len_q);
    nofit        = sum_w > limit_w;
    full         = nofit && (ws_q >= LAST_SLOT);
    ws_new       = nofit ? ws_inc : ws_q;
    wp_place     = nofit ? base_ws_inc : wp_q;
    erased_place = nofit ? 1'b0 : erased_q;
    wp_adv       = wp_place + 32'(len_q);
    cnt_sum      = {1'b0, cnt_q} + 14'(len_q);
    cnt_sat      = (cnt_sum > 14'(COUNT_MAX)) ? COUNT_MAX : cnt_sum[12:0];
    ckpt_hit     = cnt_sat >= ckpt_bytes_q;

    rs_inc       = rs_q + 2'd1;
    end_cur      = wend_q[rs_q];
    end_next     = wend_q[rs_inc];
    base_rs_inc  = slot_base_q[rs_inc];
    rd_far       = ({1'b0, rp_q} + 33'(READ_CHUNK_W)) < {1'b0, end_cur};
    rd_rest      = rp_q < end_cur;
    diff_cur     = end_cur - rp_q;
    diff_next    = end_next - base_rs_inc;
    // Entering the next slot: clip to its written data and to one chunk.
    if (end_next > base_rs_inc) begin
      len_next = (diff_next > READ_CHUNK_W) ? READ_CHUNK_W : diff_next;
    end else begin
      len_next = '0;
    end
  end

  always_comb begin
    wp_d         = wp_q;
    rp_d         = rp_q;
    ws_d         = ws_q;
    rs_d         = rs_q;
    erased_d     = erased_q;
    wend_d       = wend_q;
    cnt_d        = cnt_q;
    status_d     = 1'b0;
    erase_now_d  = 1'b0;
    erase_slot_d = '0;
    start_d      = '0;
    blen_d       = '0;
    ckpt_d       = 1'b0;
    case (req_q)
      REQ_APPEND: begin
        if (full) begin
          status_d = 1'b1;
        end else begin
          ws_d           = ws_new;
          erased_d       = 1'b1;
          wp_d           = wp_adv;
          wend_d[ws_new] = wp_adv;
          erase_now_d    = !erased_place;
          erase_slot_d   = ws_new;
          start_d        = wp_place;
          blen_d         = 11'(len_q);
          ckpt_d         = ckpt_hit;
          cnt_d          = ckpt_hit ? '0 : cnt_sat;
        end
      end
      REQ_READ: begin
        if (rd_far) begin
          start_d = rp_q;
          blen_d  = READ_CHUNK_W[10:0];
          rp_d    = rp_q + READ_CHUNK_W;
        end else if (rd_rest) begin
          start_d = rp_q;
          blen_d  = diff_cur[10:0];
          rp_d    = end_cur;
        end else if (rs_q < ws_q) begin
          rs_d    = rs_inc;
          start_d = base_rs_inc;
          blen_d  = len_next[10:0];
          rp_d    = base_rs_inc + len_next;
        end else begin
          status_d = 1'b1;
        end
      end
      REQ_CLEAR: begin
        wp_d     = slot_base_q[0];
        rp_d     = slot_base_q[0];
        ws_d     = '0;
        rs_d     = '0;
        erased_d = 1'b0;
        for (int i = 0; i < 4; i++) begin
          wend_d[i] = '0;
        end
      end
      default: begin
        status_d = 1'b1;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_base_q[0] <= SLOT0_BASE_RST;
      slot_base_q[1] <= SLOT1_BASE_RST;
      slot_base_q[2] <= SLOT2_BASE_RST;
      slot_base_q[3] <= SLOT3_BASE_RST;
      first_span_q   <= FIRST_SPAN_RST;
      other_span_q   <= OTHER_SPAN_RST;
      ckpt_bytes_q   <= CKPT_BYTES_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SLOT0_BASE: slot_base_q[0] <= cfg_data_i;
        CFG_SLOT1_BASE: slot_base_q[1] <= cfg_data_i;
        CFG_SLOT2_BASE: slot_base_q[2] <= cfg_data_i;
        CFG_SLOT3_BASE: slot_base_q[3] <= cfg_data_i;
        CFG_FIRST_SPAN: first_span_q   <= cfg_data_i[21:0];
        CFG_OTHER_SPAN: other_span_q   <= cfg_data_i[21:0];
        CFG_CKPT_BYTES: ckpt_bytes_q   <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Log state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= SLOT0_BASE_RST;
      rp_q     <= SLOT0_BASE_RST;
      ws_q     <= '0;
      rs_q     <= '0;
      erased_q <= 1'b0;
      cnt_q    <= '0;
      for (int i = 0; i < 4; i++) begin
        wend_q[i] <= '0;
      end
    end else if (fire) begin
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      ws_q     <= ws_d;
      rs_q     <= rs_d;
      erased_q <= erased_d;
      cnt_q    <= cnt_d;
      wend_q   <= wend_d;
    end
  end

  // Valid flags of the two stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_type_i;
      len_q <= record_length_i;
    end
    if (fire) begin
      status_q     <= status_d;
      erase_now_q  <= erase_now_d;
      erase_slot_q <= erase_slot_d;
      start_q      <= start_d;
      blen_q       <= blen_d;
      ckpt_q       <= ckpt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign erase_now_o     = erase_now_q;
  assign erase_slot_o    = erase_slot_q;
  assign start_address_o = start_q;
  assign byte_length_o   = blen_q;
  assign checkpoint_o    = ckpt_q;

endmodule
